// File: hdl/ldst_pkg.sv
package ldst_pkg;

    // Field widths
    localparam int unsigned HoldW  = 8;
    localparam int unsigned TickW  = 16;
    localparam int unsigned DayW   = 14;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned CfgIdxW = 2;

    // Register reset values
    localparam logic [HoldW-1:0] DebounceHoldRst = 8'd100;
    localparam logic [TickW-1:0] TicksPerStepRst = 16'd40150;
    localparam logic [DayW-1:0]  StepsPerDayRst  = 14'd8640;

    // Smallest usable day length
    localparam logic [DayW-1:0]  MinStepsPerDay  = 14'd2;

    // Number of captured switch times once configured
    localparam logic [1:0]       CapturedFull    = 2'd2;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE_HOLD  = 2'd0,
        REG_TICKS_PER_STEP = 2'd1,
        REG_STEPS_PER_DAY  = 2'd2
    } cfg_reg_t;

    // One result word
    typedef struct packed {
        logic            lamp_on;
        logic            led_on;
        logic            is_configured;
        logic [DayW-1:0] time_of_day;
    } result_t;

endpackage

// File: hdl/ldst_core.sv
module ldst_core
    import ldst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    input  logic               tick,
    input  logic               button_level,
    output result_t            result
);

    logic [HoldW-1:0] debounce_hold_reg;
    logic [TickW-1:0] ticks_per_step_reg;
    logic [DayW-1:0]  steps_per_day_reg;

    logic [TickW-1:0] prescale_reg, prescale_next;
    logic [DayW-1:0]  day_step_reg, day_step_next;
    logic [DayW-1:0]  on_time_reg, on_time_next;
    logic [DayW-1:0]  off_time_reg, off_time_next;
    logic [1:0]       captured_reg, captured_next;
    logic [HoldW-1:0] hold_reg, hold_next;
    logic             stable_reg, stable_next;
    logic             prev_reg, prev_next;
    logic             lamp_reg, lamp_next;
    logic             led_reg, led_next;

    logic             configured;
    logic             press;
    logic [HoldW-1:0] hold_loaded;
    logic [TickW-1:0] prescale_inc;
    logic [DayW-1:0]  day_inc;
    logic             lamp_step;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_hold_reg  <= DebounceHoldRst;
            ticks_per_step_reg <= TicksPerStepRst;
            steps_per_day_reg  <= StepsPerDayRst;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE_HOLD:  debounce_hold_reg  <= cfg_data[HoldW-1:0];
                REG_TICKS_PER_STEP: ticks_per_step_reg <= cfg_data[TickW-1:0];
                REG_STEPS_PER_DAY:  steps_per_day_reg  <= cfg_data[DayW-1:0];
                default: ;
            endcase
        end
    end

    assign configured = (captured_reg == CapturedFull);

    // Debounce the button while unconfigured
    always_comb
    begin
        hold_loaded = (button_level != prev_reg) ? debounce_hold_reg : hold_reg;
        hold_next   = hold_reg;
        stable_next = stable_reg;
        prev_next   = prev_reg;
        press       = 1'b0;
        if (!configured)
        begin
            prev_next = button_level;
            if (hold_loaded != '0)
            begin
                hold_next = hold_loaded - HoldW'(1);
            end
            else
            begin
                hold_next = hold_loaded;
                if (button_level != stable_reg)
                begin
                    stable_next = button_level;
                    press       = button_level;
                end
            end
        end
    end

    // Advance prescaler, day counter, LED and lamp
    always_comb
    begin
        prescale_inc  = prescale_reg + TickW'(1);
        day_inc       = day_step_reg + DayW'(1);
        prescale_next = prescale_inc;
        day_step_next = day_step_reg;
        led_next      = led_reg;
        lamp_step     = lamp_reg;
        if (prescale_inc == ticks_per_step_reg)
        begin
            prescale_next = '0;
            if (day_inc == steps_per_day_reg || steps_per_day_reg < MinStepsPerDay)
                day_step_next = '0;
            else
                day_step_next = day_inc;
            if (configured)
            begin
                led_next = ~led_reg;
                if (day_step_next == on_time_reg)
                    lamp_step = 1'b1;
                else if (day_step_next == off_time_reg)
                    lamp_step = 1'b0;
            end
        end
    end

    // Capture switch times and flip the lamp on a press
    always_comb
    begin
        on_time_next  = on_time_reg;
        off_time_next = off_time_reg;
        captured_next = captured_reg;
        lamp_next     = lamp_step;
        if (press)
        begin
            if (captured_reg == '0)
                on_time_next = day_step_next;
            else
                off_time_next = day_step_next;
            captured_next = captured_reg + 2'd1;
            lamp_next     = ~lamp_step;
        end
    end

    // Hold state, update on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            day_step_reg <= '0;
            on_time_reg  <= '0;
            off_time_reg <= '0;
            captured_reg <= '0;
            hold_reg     <= '0;
            stable_reg   <= 1'b0;
            prev_reg     <= 1'b0;
            lamp_reg     <= 1'b0;
            led_reg      <= 1'b1;
        end
        else if (tick)
        begin
            prescale_reg <= prescale_next;
            day_step_reg <= day_step_next;
            on_time_reg  <= on_time_next;
            off_time_reg <= off_time_next;
            captured_reg <= captured_next;
            hold_reg     <= hold_next;
            stable_reg   <= stable_next;
            prev_reg     <= prev_next;
            lamp_reg     <= lamp_next;
            led_reg      <= led_next;
        end
    end

    // Form the result word from the next state
    always_comb
    begin
        result.lamp_on       = lamp_next;
        result.led_on        = led_next;
        result.is_configured = (captured_next == CapturedFull);
        result.time_of_day   = day_step_next;
    end

endmodule

// File: hdl/learned_daily_switch_timer.sv
// Lamp timer that learns its daily on and off times from two button presses.
// Input channel: in_valid / in_stall carry one base tick with the raw button
// level. Output channel: out_valid / out_stall return one result word per tick
// (lamp_on, led_on, is_configured, time_of_day).
// Configuration: cfg_we with cfg_index and cfg_data writes debounce_hold (0),
// ticks_per_step (1) or steps_per_day (2); write only while the block is idle.
// A tick accepted at an edge is loaded into the result register, or into the
// skid register while the output stalls. Throughput: one tick per cycle while
// in_stall is low; the whole tick update is one pass of counter increments
// and compares between the state registers and the result register.
// A two-word output stage (result register plus skid register) lets a tick be
// accepted while the previous result is still stalled; in_stall rises only
// when both words are full, and no word is dropped or repeated.
// Reset (rst_n low, asynchronous) restores the register defaults, clears the
// counters and captured times, turns the lamp off and the LED on, and empties
// the output stage.
module learned_daily_switch_timer
    import ldst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               button_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               lamp_on,
    output logic               led_on,
    output logic               is_configured,
    output logic [DayW-1:0]    time_of_day
);

    logic    take_in;
    logic    out_free;
    result_t new_word;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    assign in_stall = skid_valid_reg;
    assign take_in  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    ldst_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick         (take_in),
        .button_level (button_level),
        .result       (new_word)
    );

    // Track which output words hold results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || take_in;
            skid_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Load the result and skid words
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (take_in)
                out_reg <= new_word;
        end
        else if (take_in)
        begin
            skid_reg <= new_word;
        end
    end

    assign out_valid     = out_valid_reg;
    assign lamp_on       = out_reg.lamp_on;
    assign led_on        = out_reg.led_on;
    assign is_configured = out_reg.is_configured;
    assign time_of_day   = out_reg.time_of_day;

endmodule

// File: tb/sv/tb_learned_daily_switch_timer.sv
module tb_learned_daily_switch_timer;
    import ldst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register values after reset and the rule limits of the timer
    localparam int unsigned HOLD_AT_RESET   = 100;
    localparam int unsigned TICKS_AT_RESET  = 40150;
    localparam int unsigned DAY_AT_RESET    = 8640;
    localparam int unsigned SHORTEST_DAY    = 2;
    localparam int unsigned LONGEST_DAY     = 16383;
    localparam logic [1:0]  BOTH_LEARNED    = 2'd2;
    localparam int          REPORT_LIMIT    = 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0]    cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               button_level = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               lamp_on;
    logic               led_on;
    logic               is_configured;
    logic [DayW-1:0]    time_of_day;

    // Timer settings as the block should hold them
    logic [HoldW-1:0] hold_cfg;
    logic [TickW-1:0] tps_cfg;
    logic [DayW-1:0]  spd_cfg;

    // Timer state as the block should hold it
    logic [TickW-1:0] tick_count;
    logic [DayW-1:0]  day_pos;
    logic [DayW-1:0]  on_at;
    logic [DayW-1:0]  off_at;
    logic [1:0]       learned;
    logic [HoldW-1:0] hold_left;
    logic             settled_lvl;
    logic             last_lvl;
    logic             lamp_lvl;
    logic             led_lvl;

    // Button words waiting to go out, status words waiting to come back
    logic    button_ticks[$];
    result_t status_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit in_taken = 1'b0;
    int ticks_taken = 0;
    int status_checked = 0;
    int regs_written = 0;
    int error_count = 0;

    learned_daily_switch_timer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_level  (button_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lamp_on       (lamp_on),
        .led_on        (led_on),
        .is_configured (is_configured),
        .time_of_day   (time_of_day)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Restore the timer to its power-up state
    task automatic reset_timer_state;
        hold_cfg    = HoldW'(HOLD_AT_RESET);
        tps_cfg     = TickW'(TICKS_AT_RESET);
        spd_cfg     = DayW'(DAY_AT_RESET);
        tick_count  = '0;
        day_pos     = '0;
        on_at       = '0;
        off_at      = '0;
        learned     = '0;
        hold_left   = '0;
        settled_lvl = 1'b0;
        last_lvl    = 1'b0;
        lamp_lvl    = 1'b0;
        led_lvl     = 1'b1;
    endtask

    // Advance the timer by one base tick and return the status it shows
    function automatic result_t predict_status(input logic lvl);
        result_t word;
        logic    press;
        press = 1'b0;
        // Debounce only while the switch times are still being learned
        if (learned != BOTH_LEARNED)
        begin
            if (lvl != last_lvl)
                hold_left = hold_cfg;
            if (hold_left != '0)
                hold_left = hold_left - 1'b1;
            else if (lvl != settled_lvl)
            begin
                settled_lvl = lvl;
                press = lvl;
            end
            last_lvl = lvl;
        end
        // Prescaler, then the time-of-day step
        tick_count = tick_count + 1'b1;
        if (tick_count == tps_cfg)
        begin
            tick_count = '0;
            day_pos = day_pos + 1'b1;
            if (day_pos == spd_cfg || spd_cfg < SHORTEST_DAY)
                day_pos = '0;
            if (learned == BOTH_LEARNED)
            begin
                led_lvl = ~led_lvl;
                if (day_pos == on_at)
                    lamp_lvl = 1'b1;
                else if (day_pos == off_at)
                    lamp_lvl = 1'b0;
            end
        end
        // A press captures the current step and flips the lamp
        if (press && learned != BOTH_LEARNED)
        begin
            if (learned == 2'd0)
                on_at = day_pos;
            else
                off_at = day_pos;
            learned = learned + 1'b1;
            lamp_lvl = ~lamp_lvl;
        end
        word.lamp_on       = lamp_lvl;
        word.led_on        = led_lvl;
        word.is_configured = (learned == BOTH_LEARNED);
        word.time_of_day   = day_pos;
        return word;
    endfunction

    task automatic check_field(input string field, input logic [DayW-1:0] want_v,
                               input logic [DayW-1:0] got_v);
        if (got_v !== want_v)
        begin
            if (error_count < REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", field, want_v, got_v);
            error_count++;
        end
    endtask

    // Drive the button word and the result stall between rising edges
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (button_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid     <= 1'b1;
                    button_level <= button_ticks.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Check each status word leaving, then predict for each button word entering
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $error("status word arrived with none outstanding");
                    error_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("lamp_on", DayW'(want.lamp_on), DayW'(lamp_on));
                    check_field("led_on", DayW'(want.led_on), DayW'(led_on));
                    check_field("is_configured", DayW'(want.is_configured),
                                DayW'(is_configured));
                    check_field("time_of_day", want.time_of_day, time_of_day);
                    status_checked++;
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                status_due.push_back(predict_status(button_level));
                ticks_taken++;
            end
        end
    end

    // Hold until every button word is in and every status word is back
    task automatic drain_status;
        while (button_ticks.size() != 0 || in_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CfgW-1:0];
        case (idx)
            REG_DEBOUNCE_HOLD:  hold_cfg = val[HoldW-1:0];
            REG_TICKS_PER_STEP: tps_cfg  = val[TickW-1:0];
            REG_STEPS_PER_DAY:  spd_cfg  = val[DayW-1:0];
            default: ;
        endcase
        @(posedge clk);
        regs_written++;
    endtask

    // Write all three registers; call only once the timer is drained
    task automatic apply_settings(input int unsigned hold, input int unsigned ticks,
                                  input int unsigned days);
        write_reg(REG_DEBOUNCE_HOLD, hold);
        write_reg(REG_TICKS_PER_STEP, ticks);
        write_reg(REG_STEPS_PER_DAY, days);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_level(input logic lvl, input int count);
        repeat (count) button_ticks.push_back(lvl);
    endtask

    task automatic push_random(input int count);
        repeat (count) button_ticks.push_back(1'($urandom_range(0, 1)));
    endtask

    // Bounce the button without ever holding it long enough to count as a press
    task automatic push_bounces(input int target, input int hold);
        int n;
        int len;
        n = 0;
        while (n < target)
        begin
            len = $urandom_range(1, (hold + 2 < 16) ? hold + 2 : 16);
            push_level(1'b0, len);
            n += len;
            len = ($urandom_range(0, 3) == 0) ? hold : $urandom_range(1, hold);
            push_level(1'b1, len);
            n += len;
        end
        push_level(1'b0, 1);
    endtask

    // Keep the step period ahead of the prescaler so steps keep coming
    function automatic int unsigned pick_step_ticks(input int unsigned hi);
        int unsigned v;
        v = $urandom_range(1, hi);
        if (v <= tick_count)
            v = tick_count + 1;
        return v;
    endfunction

    // Day length around the off time, now and then degenerate or the longest
    function automatic int unsigned pick_day_len;
        int unsigned v;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = $urandom_range(0, 1);
        else if (r == 1)
            v = LONGEST_DAY;
        else
            v = off_at + $urandom_range(1, 15);
        if (v >= SHORTEST_DAY && v <= day_pos)
            v = day_pos + 1;
        return v;
    endfunction

    initial
    begin : stimulus
        int unsigned h;
        int unsigned days;
        reset_timer_state();
        send_idle_pct = 30;
        recv_idle_pct = 66;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-up values; a short blip of the button must not count
        push_level(1'b0, 2);
        push_level(1'b1, 2);
        push_level(1'b0, 2);
        drain_status();

        // Zero hold takes a level at once; zero period leaves the prescaler
        // behind its register; a one-step day wraps on every step
        apply_settings(0, 0, 1);
        push_level(1'b1, 2);
        push_level(1'b0, 2);
        drain_status();

        // Bring the prescaler back into step
        apply_settings(0, tick_count + 2, 1);
        push_level(1'b0, 4);
        drain_status();

        // Widest settings
        apply_settings(255, 65535, LONGEST_DAY);
        push_level(1'b1, 2);
        push_level(1'b0, 1);
        push_level(1'b1, 1);
        push_level(1'b0, 1);

        for (int ph = 0; ph < 23; ph++)
        begin
            drain_status();
            if (ph == 8)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 30;
            end
            else if (ph == 16)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (ph < 9)
            begin
                // Bouncing button while one switch time is known
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
                apply_settings(h, pick_step_ticks(8), pick_day_len());
                push_bounces(45, h);
            end
            else if (ph == 9)
            begin
                // Second press at a step that differs from the first
                h = $urandom_range(1, 12);
                days = (day_pos + 200 > LONGEST_DAY) ? LONGEST_DAY : day_pos + 200;
                apply_settings(h, tick_count + 1, days);
                push_level(1'b0, $urandom_range(1, 8));
                push_level(1'b1, h + 1 + $urandom_range(0, 3));
                push_random(30);
            end
            else
            begin
                // Learned schedule running; the button no longer matters
                apply_settings($urandom_range(0, 255), pick_step_ticks(3), pick_day_len());
                push_random($urandom_range(30, 70));
            end
        end

        // Step with the longest day, then with a day no longer than the current step
        drain_status();
        apply_settings(32'(hold_cfg), tick_count + 1, LONGEST_DAY);
        push_random(1);
        drain_status();
        apply_settings(32'(hold_cfg), 1, LONGEST_DAY);
        push_random(4);
        drain_status();
        days = $urandom_range(SHORTEST_DAY, day_pos);
        apply_settings(32'(hold_cfg), 1, days);
        push_random(24);

        drain_status();
        repeat (10) @(negedge clk);
        $display("Checked %0d status words from %0d button ticks over %0d register writes.",
                 status_checked, ticks_taken, regs_written);
        $display("Schedule learned from two presses: lamp on at step %0d, off at step %0d.",
                 on_at, off_at);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: learned_daily_switch_timer.f
hdl/ldst_pkg.sv
hdl/ldst_core.sv
hdl/learned_daily_switch_timer.sv
tb/sv/tb_learned_daily_switch_timer.sv
